// ===== hw/rtl/bmhq_pkg.sv =====
// Shared types and constants of the binary min-heap queue.
package bmhq_pkg;

    localparam int KEY_W      = 32;
    localparam int TOTAL_W    = 11;
    localparam int STATUS_W   = 2;
    localparam int OUT_DATA_W = 80;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_PUT,
        ST_DQ_LOAD,
        ST_DN_SEL,
        ST_DN_MOV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]    key_out;
        logic [KEY_W-1:0]    min_key;
        logic [TOTAL_W-1:0]  entry_total;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

// ===== hw/rtl/bmhq_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== hw/rtl/bmhq_cmp.sv =====
// Shared signed key comparator of the heap sequencer.
module bmhq_cmp
    import bmhq_pkg::*;
(
    input  logic [KEY_W-1:0] i_a,
    input  logic [KEY_W-1:0] i_b,
    output logic             o_less
);

    assign o_less = $signed(i_a) < $signed(i_b);

endmodule

// ===== hw/rtl/bmhq_ctrl.sv =====
// Sift sequencer of the heap: walks one level per step through the shared comparator.
module bmhq_ctrl
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic                        i_req_type,
    input  logic [KEY_W-1:0]            i_key,
    output logic                        o_res_valid,
    input  logic                        i_res_ack,
    output t_result                     o_res,
    output logic                        o_ram_we,
    output logic [$clog2(CAPACITY)-1:0] o_ram_waddr,
    output logic [KEY_W-1:0]            o_ram_wdata,
    output logic                        o_ram_re,
    output logic [$clog2(CAPACITY)-1:0] o_ram_raddr_a,
    output logic [$clog2(CAPACITY)-1:0] o_ram_raddr_b,
    input  logic [KEY_W-1:0]            i_ram_rdata_a,
    input  logic [KEY_W-1:0]            i_ram_rdata_b
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;
    localparam int AW = $clog2(CAPACITY);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [SW-1:0]       r_pos, n_pos;
    logic [SW-1:0]       r_chpos, n_chpos;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [KEY_W-1:0]    r_child, n_child;
    logic [KEY_W-1:0]    r_min, n_min;
    logic [KEY_W-1:0]    r_removed, n_removed;
    logic [STATUS_W-1:0] r_status, n_status;

    logic [KEY_W-1:0]    cmp_a, cmp_b;
    logic                cmp_less;
    logic [SW-1:0]       count_ext, count_inc, ch, ch_r, nch, par;
    logic                take_r;
    logic [CW+TOTAL_W-1:0] total_ext;

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s);
        logic [SW-1:0] d;
        d = s - SW'(1);
        return d[AW-1:0];
    endfunction

    bmhq_cmp u_cmp (
        .i_a    (cmp_a),
        .i_b    (cmp_b),
        .o_less (cmp_less)
    );

    assign count_ext = {1'b0, r_count};
    assign count_inc = count_ext + SW'(1);
    assign ch        = {r_pos[SW-2:0], 1'b0};
    assign ch_r      = {r_pos[SW-2:0], 1'b1};
    assign nch       = {r_chpos[SW-2:0], 1'b0};
    assign par       = r_pos >> 1;
    assign take_r    = (ch < count_ext) && cmp_less;
    assign total_ext = {{TOTAL_W{1'b0}}, r_count};

    assign o_req_ready       = (r_state == ST_IDLE);
    assign o_res_valid       = (r_state == ST_DONE);
    assign o_res.key_out     = r_removed;
    assign o_res.min_key     = (r_count != '0) ? r_min : '0;
    assign o_res.entry_total = total_ext[TOTAL_W-1:0];
    assign o_res.status      = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos     <= n_pos;
        r_chpos   <= n_chpos;
        r_key     <= n_key;
        r_child   <= n_child;
        r_min     <= n_min;
        r_removed <= n_removed;
        r_status  <= n_status;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pos         = r_pos;
        n_chpos       = r_chpos;
        n_key         = r_key;
        n_child       = r_child;
        n_min         = r_min;
        n_removed     = r_removed;
        n_status      = r_status;
        o_ram_we      = 1'b0;
        o_ram_waddr   = slot_addr(r_pos);
        o_ram_wdata   = r_key;
        o_ram_re      = 1'b0;
        o_ram_raddr_a = slot_addr(par);
        o_ram_raddr_b = slot_addr(count_ext);
        cmp_a         = r_child;
        cmp_b         = r_key;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_removed = '0;
                    n_status  = STAT_OK;
                    if (i_req_type == REQ_ENQ) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = STAT_FULL;
                            n_state  = ST_DONE;
                        end else begin
                            n_count = count_inc[CW-1:0];
                            n_pos   = count_inc;
                            n_key   = i_key;
                            if (count_inc == SW'(1)) begin
                                n_state = ST_PUT;
                            end else begin
                                o_ram_re      = 1'b1;
                                o_ram_raddr_a = slot_addr(count_inc >> 1);
                                n_state       = ST_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                            n_state  = ST_DONE;
                        end else begin
                            o_ram_re      = 1'b1;
                            o_ram_raddr_a = slot_addr(SW'(1));
                            o_ram_raddr_b = slot_addr(count_ext);
                            n_count       = r_count - CW'(1);
                            n_state       = ST_DQ_LOAD;
                        end
                    end
                end
            end
            ST_UP: begin
                cmp_a = r_key;
                cmp_b = i_ram_rdata_a;
                o_ram_we = 1'b1;
                if (cmp_less) begin
                    o_ram_wdata = i_ram_rdata_a;
                    n_pos       = par;
                    if (par == SW'(1)) begin
                        n_state = ST_PUT;
                    end else begin
                        o_ram_re      = 1'b1;
                        o_ram_raddr_a = slot_addr(par >> 1);
                    end
                end else begin
                    o_ram_wdata = r_key;
                    n_state     = ST_DONE;
                end
            end
            ST_PUT: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = r_key;
                if (r_pos == SW'(1)) begin
                    n_min = r_key;
                end
                n_state = ST_DONE;
            end
            ST_DQ_LOAD: begin
                n_removed = i_ram_rdata_a;
                n_key     = i_ram_rdata_b;
                n_pos     = SW'(1);
                if (r_count == '0) begin
                    n_state = ST_DONE;
                end else if (count_ext < SW'(2)) begin
                    n_state = ST_PUT;
                end else begin
                    o_ram_re      = 1'b1;
                    o_ram_raddr_a = slot_addr(SW'(2));
                    o_ram_raddr_b = slot_addr(SW'(3));
                    n_state       = ST_DN_SEL;
                end
            end
            ST_DN_SEL: begin
                cmp_a   = i_ram_rdata_b;
                cmp_b   = i_ram_rdata_a;
                n_child = take_r ? i_ram_rdata_b : i_ram_rdata_a;
                n_chpos = take_r ? ch_r : ch;
                n_state = ST_DN_MOV;
            end
            ST_DN_MOV: begin
                cmp_a    = r_child;
                cmp_b    = r_key;
                o_ram_we = 1'b1;
                if (cmp_less) begin
                    o_ram_wdata = r_child;
                    if (r_pos == SW'(1)) begin
                        n_min = r_child;
                    end
                    n_pos = r_chpos;
                    if (nch > count_ext) begin
                        n_state = ST_PUT;
                    end else begin
                        o_ram_re      = 1'b1;
                        o_ram_raddr_a = slot_addr(nch);
                        o_ram_raddr_b = slot_addr(nch | SW'(1));
                        n_state       = ST_DN_SEL;
                    end
                end else begin
                    o_ram_wdata = r_key;
                    if (r_pos == SW'(1)) begin
                        n_min = r_key;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/binary_min_heap_queue_unit.sv =====
// Top level of the binary min-heap priority queue with its output register.
// An enqueue moves the key up one level per ST_UP step, ending in place or in ST_PUT at the root;
// a rejected request goes straight to ST_DONE. A dequeue loads root and last slot in ST_DQ_LOAD,
// then sinks the key one level per ST_DN_SEL/ST_DN_MOV pair; one that empties the queue ends there.
// One request is in work at a time; the next is accepted once ST_DONE has handed on the result.
// Synchronous active-low reset empties the queue; heap RAM contents are not cleared.
module binary_min_heap_queue_unit
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [KEY_W-1:0]      s_axis_tdata,  // key_in
    input  logic                  s_axis_tuser,  // req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // key_out, min_key, entry_total, zero pad
    output logic [STATUS_W-1:0]   m_axis_tuser   // status
);

    localparam int AW = $clog2(CAPACITY);

    t_result                     res;
    logic                        res_valid;
    logic                        res_ack;
    logic                        ram_we;
    logic                        ram_re;
    logic [AW-1:0]               ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [KEY_W-1:0]            ram_wdata, ram_rdata_a, ram_rdata_b;
    logic                        r_m_valid;
    logic [OUT_DATA_W-1:0]       r_m_data;
    logic [STATUS_W-1:0]         r_m_user;

    assign res_ack = !r_m_valid || m_axis_tready;

    bmhq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .o_req_ready   (s_axis_tready),
        .i_req_type    (s_axis_tuser),
        .i_key         (s_axis_tdata),
        .o_res_valid   (res_valid),
        .i_res_ack     (res_ack),
        .o_res         (res),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr_a (ram_raddr_a),
        .o_ram_raddr_b (ram_raddr_b),
        .i_ram_rdata_a (ram_rdata_a),
        .i_ram_rdata_b (ram_rdata_b)
    );

    bmhq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_ack) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (res_valid && res_ack) begin
            r_m_data <= {{(OUT_DATA_W - 2 * KEY_W - TOTAL_W){1'b0}},
                         res.entry_total, res.min_key, res.key_out};
            r_m_user <= res.status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

// ===== tb/binary_min_heap_queue_unit_tb.sv =====
// Self-checking testbench for the binary min-heap priority queue with a heap-tracking scoreboard.
`timescale 1ns / 100ps

module binary_min_heap_queue_unit_tb;
    import bmhq_pkg::*;

    localparam int QUEUE_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    class heap_report_checker;
        logic signed [KEY_W-1:0] slots [0:QUEUE_DEPTH];
        int unsigned held;
        t_result pending_reports [$];
        int errors;

        function new();
            held = 0;
            errors = 0;
        endfunction

        function void note_request(logic req, logic signed [KEY_W-1:0] key);
            t_result rpt;
            int pos;
            int par;
            int ch;
            logic signed [KEY_W-1:0] tmp;
            rpt = '0;
            if (req == REQ_ENQ) begin
                if (held >= QUEUE_DEPTH) begin
                    rpt.status = STAT_FULL;
                end else begin
                    held++;
                    slots[held] = key;
                    pos = held;
                    while (pos > 1) begin
                        par = pos / 2;
                        if (!(slots[pos] < slots[par])) break;
                        tmp = slots[pos];
                        slots[pos] = slots[par];
                        slots[par] = tmp;
                        pos = par;
                    end
                end
            end else if (held == 0) begin
                rpt.status = STAT_EMPTY;
            end else begin
                rpt.key_out = slots[1];
                slots[1] = slots[held];
                held--;
                pos = 1;
                forever begin
                    ch = 2 * pos;
                    if (ch > held) break;
                    if (ch < held && slots[ch + 1] < slots[ch]) ch++;
                    if (!(slots[ch] < slots[pos])) break;
                    tmp = slots[ch];
                    slots[ch] = slots[pos];
                    slots[pos] = tmp;
                    pos = ch;
                end
            end
            rpt.min_key = (held > 0) ? slots[1] : '0;
            rpt.entry_total = held[TOTAL_W-1:0];
            pending_reports.push_back(rpt);
        endfunction

        function void check_report(logic [OUT_DATA_W-1:0] data, logic [STATUS_W-1:0] stat);
            t_result want;
            logic [KEY_W-1:0] got_removed;
            logic [KEY_W-1:0] got_min;
            logic [TOTAL_W-1:0] got_total;
            got_removed = data[KEY_W-1:0];
            got_min = data[2*KEY_W-1:KEY_W];
            got_total = data[2*KEY_W+TOTAL_W-1:2*KEY_W];
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected transfer: key_out %h min_key %h total %0d status %0d",
                             got_removed, got_min, got_total, stat);
                return;
            end
            want = pending_reports.pop_front();
            if (got_removed !== want.key_out || got_min !== want.min_key ||
                got_total !== want.entry_total || stat !== want.status) begin
                errors++;
                if (errors <= 10)
                    $display({"Mismatch: expected key_out %h min_key %h total %0d status %0d,",
                              " got key_out %h min_key %h total %0d status %0d"},
                             want.key_out, want.min_key, want.entry_total, want.status,
                             got_removed, got_min, got_total, stat);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [KEY_W-1:0]      s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    heap_report_checker heap_chk;
    int cycles;
    bit send_burst;
    bit recv_burst;

    binary_min_heap_queue_unit #(
        .CAPACITY(QUEUE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("binary_min_heap_queue_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0) burst = ~burst;
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic req, input logic [KEY_W-1:0] key);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        heap_chk.note_request(req, key);
    endtask

    task automatic send_mixed(input int count, input int enq_percent);
        repeat (count) begin
            if ($urandom_range(0, 99) < enq_percent) send_request(REQ_ENQ, pick_key());
            else send_request(REQ_DEQ, $urandom);
        end
    endtask

    initial begin
        int gap;
        forever begin
            gap = draw_gap(recv_burst);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            heap_chk.check_report(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin
        logic [KEY_W-1:0] edge_keys [10];
        edge_keys = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                      32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'hAAAA_AAAA, 32'h5555_5555};
        heap_chk = new();
        cycles = 0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= REQ_ENQ;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_DEQ, 32'h0000_0000);
        foreach (edge_keys[k]) send_request(REQ_ENQ, edge_keys[k]);
        repeat (10) send_request(REQ_DEQ, $urandom);
        send_request(REQ_DEQ, 32'hFFFF_FFFF);

        send_mixed(150, 55);
        while (heap_chk.held < QUEUE_DEPTH) send_request(REQ_ENQ, pick_key());
        repeat (3) send_request(REQ_ENQ, pick_key());
        send_mixed(150, 30);

        s_axis_tvalid <= 1'b0;
        while (heap_chk.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (heap_chk.errors == 0 && heap_chk.pending_reports.size() == 0) begin
            $display("binary_min_heap_queue_unit_tb: PASS");
        end else begin
            $display("binary_min_heap_queue_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_ram.sv
hw/rtl/bmhq_cmp.sv
hw/rtl/bmhq_ctrl.sv
hw/rtl/binary_min_heap_queue_unit.sv
tb/binary_min_heap_queue_unit_tb.sv
